@@ rtl/core/tslb_pkg.sv @@
`timescale 1ns / 1ps

package tslb_pkg;

  localparam int LINE_CHARS_DEF    = 160;
  localparam int HISTORY_DEPTH_DEF = 64;
  localparam int QUEUE_DEPTH       = 4;
  localparam int TAB_WIDTH         = 4;

  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_DEL    = 8'd127;
  localparam logic [7:0] CH_BS     = 8'd8;
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_UP_J   = 8'h4A;
  localparam logic [7:0] CH_UP_K   = 8'h4B;
  localparam logic [7:0] CH_UP_H   = 8'h48;
  localparam logic [7:0] CH_LO_F   = 8'h66;

  typedef enum logic [1:0] {
    CMD_PLAIN,
    CMD_CLR_SCREEN,
    CMD_CLR_LINE_CR,
    CMD_CLR_LINE
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e    op;
    logic [7:0] ch;
  } cmd_t;

  typedef enum logic [2:0] {
    EV_PUT          = 3'd0,
    EV_ERASE        = 3'd1,
    EV_CLEAR_LINE   = 3'd2,
    EV_COMMIT       = 3'd3,
    EV_CLEAR_SCREEN = 3'd4
  } ev_kind_e;

  typedef struct packed {
    ev_kind_e   kind;
    logic [7:0] position;
    logic [7:0] char_out;
    logic [7:0] line_length;
    logic       last;
  } event_t;

endpackage

@@ rtl/core/terminal_stream_line_builder.sv @@
`timescale 1ns / 1ps

// Channel   Dir  tdata                                        tuser        tlast
// s_axis    in   [7:0] byte_in                                -            -
// m_axis    out  [7:0] position, [15:8] char_out,             event_kind   last_event
//                [23:16] line_length
//
// The parser takes one byte per cycle while the command queue has room.
// The executor gives one event per cycle from a registered output while m_axis accepts;
// a tab gives up to four puts, plus one line clear when a CR is pending.
// A byte's first event passes through the command queue and then the registered output before it is valid on m_axis.
// Reset clears parser, line and ring state at once; no clearing pass.
// m_axis stalls hold the executor; the queue lets input run on meanwhile.

module terminal_stream_line_builder #(
  parameter int LINE_CHARS    = tslb_pkg::LINE_CHARS_DEF,
  parameter int HISTORY_DEPTH = tslb_pkg::HISTORY_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] byte_in
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [7:0] position, [15:8] char_out, [23:16] line_length
  output logic [2:0]  m_axis_tuser_o,   // [2:0] event_kind
  output logic        m_axis_tlast_o    // last_event
);
  import tslb_pkg::*;

  logic   push, full, pop, head_valid;
  cmd_t   push_cmd, head_cmd;
  event_t ev;

  tslb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(s_axis_tvalid_i),
    .byte_i      (s_axis_tdata_i),
    .byte_ready_o(s_axis_tready_o),
    .cmd_valid_o (push),
    .cmd_o       (push_cmd),
    .cmd_full_i  (full)
  );

  tslb_cmd_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .full_o    (full),
    .pop_i     (pop),
    .valid_o   (head_valid),
    .head_o    (head_cmd)
  );

  tslb_back #(
    .LINE_CHARS   (LINE_CHARS),
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(head_valid),
    .cmd_i      (head_cmd),
    .cmd_pop_o  (pop),
    .ev_valid_o (m_axis_tvalid_o),
    .ev_o       (ev),
    .ev_ready_i (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {ev.line_length, ev.char_out, ev.position};
  assign m_axis_tuser_o = ev.kind;
  assign m_axis_tlast_o = ev.last;

endmodule

@@ rtl/core/tslb_front.sv @@
`timescale 1ns / 1ps

module tslb_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          byte_valid_i,
  input  logic [7:0]    byte_i,
  output logic          byte_ready_o,
  output logic          cmd_valid_o,
  output tslb_pkg::cmd_t cmd_o,
  input  logic          cmd_full_i
);
  import tslb_pkg::*;

  logic       in_escape_q, in_escape_d;
  logic       in_csi_q, in_csi_d;
  logic [7:0] csi_param_q, csi_param_d;
  logic       accept;
  logic       plain;
  logic       is_digit, is_letter;
  logic [11:0] param_next;

  assign byte_ready_o = !cmd_full_i;
  assign accept       = byte_valid_i && !cmd_full_i;

  assign is_digit  = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign is_letter = ((byte_i >= CH_UP_A) && (byte_i <= CH_UP_Z)) ||
                     ((byte_i >= CH_LO_A) && (byte_i <= CH_LO_Z));
  // param * 10 + digit
  assign param_next = {1'b0, csi_param_q, 3'b000} + {3'b000, csi_param_q, 1'b0} +
                      {8'h00, byte_i[3:0]};

  always_comb begin
    in_escape_d = in_escape_q;
    in_csi_d    = in_csi_q;
    csi_param_d = csi_param_q;
    cmd_valid_o = 1'b0;
    cmd_o.op    = CMD_PLAIN;
    cmd_o.ch    = byte_i;
    plain       = 1'b0;
    if (accept) begin
      if (in_escape_q && !in_csi_q) begin
        if (byte_i == CH_LBRACK) begin
          in_csi_d    = 1'b1;
          csi_param_d = '0;
        end else begin
          in_escape_d = 1'b0;
          csi_param_d = '0;
          plain       = 1'b1;
        end
      end else if (in_escape_q) begin
        if (is_digit) begin
          csi_param_d = (param_next > 12'd255) ? 8'd255 : param_next[7:0];
        end else if (byte_i == CH_SEMI || byte_i == CH_QUEST) begin
          csi_param_d = csi_param_q;
        end else begin
          in_escape_d = 1'b0;
          in_csi_d    = 1'b0;
          csi_param_d = '0;
          if (is_letter) begin
            if (byte_i == CH_UP_J) begin
              if (csi_param_q == 8'd0 || csi_param_q == 8'd2) begin
                cmd_valid_o = 1'b1;
                cmd_o.op    = CMD_CLR_SCREEN;
              end
            end else if (byte_i == CH_UP_H || byte_i == CH_LO_F) begin
              cmd_valid_o = 1'b1;
              cmd_o.op    = CMD_CLR_LINE_CR;
            end else if (byte_i == CH_UP_K) begin
              cmd_valid_o = 1'b1;
              cmd_o.op    = CMD_CLR_LINE;
            end
          end
        end
      end else begin
        plain = 1'b1;
      end
      if (plain) begin
        if (byte_i == CH_ESC) begin
          in_escape_d = 1'b1;
          in_csi_d    = 1'b0;
          csi_param_d = '0;
        end else begin
          cmd_valid_o = 1'b1;
          cmd_o.op    = CMD_PLAIN;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_escape_q <= 1'b0;
      in_csi_q    <= 1'b0;
      csi_param_q <= '0;
    end else begin
      in_escape_q <= in_escape_d;
      in_csi_q    <= in_csi_d;
      csi_param_q <= csi_param_d;
    end
  end

endmodule

@@ rtl/core/tslb_cmd_fifo.sv @@
`timescale 1ns / 1ps

module tslb_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tslb_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output tslb_pkg::cmd_t head_o
);
  import tslb_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/tslb_back.sv @@
`timescale 1ns / 1ps

module tslb_back #(
  parameter int LINE_CHARS    = tslb_pkg::LINE_CHARS_DEF,
  parameter int HISTORY_DEPTH = tslb_pkg::HISTORY_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  tslb_pkg::cmd_t   cmd_i,
  output logic             cmd_pop_o,
  output logic             ev_valid_o,
  output tslb_pkg::event_t ev_o,
  input  logic             ev_ready_i
);
  import tslb_pkg::*;

  localparam int RING_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;

  logic              cr_pending_q, cr_pending_d;
  logic [7:0]        cur_len_q, cur_len_d;
  logic [RING_W-1:0] ring_head_q, ring_head_d;
  logic [CNT_W-1:0]  ring_count_q, ring_count_d;
  logic [1:0]        tab_cnt_q, tab_cnt_d;
  logic              out_valid_q;
  event_t            ev_q, ev_d;

  logic              out_free, emit;
  logic [7:0]        c;
  logic              is_tab, is_print, line_full, tab_end;
  logic [8:0]        len_p1, len_p2;
  logic [SUM_W-1:0]  slot_sum;
  logic [RING_W-1:0] slot;
  logic [RING_W:0]   head_p1;

  assign out_free = !out_valid_q || ev_ready_i;
  assign c        = cmd_i.ch;
  assign is_tab   = (c == CH_TAB);
  assign is_print = (c >= CH_SPACE) && (c != CH_DEL);
  assign len_p1   = {1'b0, cur_len_q} + 9'd1;
  assign len_p2   = {1'b0, cur_len_q} + 9'd2;
  assign line_full = (len_p1 >= 9'(LINE_CHARS));
  assign tab_end  = (tab_cnt_q == 2'(TAB_WIDTH - 1)) || (len_p2 >= 9'(LINE_CHARS));

  // next free slot, head + count folded once
  assign slot_sum = SUM_W'(ring_head_q) + SUM_W'(ring_count_q);
  assign slot     = (slot_sum >= SUM_W'(HISTORY_DEPTH)) ?
                    RING_W'(slot_sum - SUM_W'(HISTORY_DEPTH)) : RING_W'(slot_sum);
  assign head_p1  = {1'b0, ring_head_q} + 1'b1;

  always_comb begin
    cr_pending_d = cr_pending_q;
    cur_len_d    = cur_len_q;
    ring_head_d  = ring_head_q;
    ring_count_d = ring_count_q;
    tab_cnt_d    = tab_cnt_q;
    emit         = 1'b0;
    cmd_pop_o    = 1'b0;
    ev_d         = '0;
    ev_d.kind    = EV_PUT;
    if (cmd_valid_i && out_free) begin
      case (cmd_i.op)
        CMD_CLR_SCREEN: begin
          emit         = 1'b1;
          ev_d.kind    = EV_CLEAR_SCREEN;
          ev_d.last    = 1'b1;
          cur_len_d    = '0;
          cr_pending_d = 1'b0;
          ring_head_d  = '0;
          ring_count_d = '0;
          cmd_pop_o    = 1'b1;
        end
        CMD_CLR_LINE_CR, CMD_CLR_LINE: begin
          emit      = 1'b1;
          ev_d.kind = EV_CLEAR_LINE;
          ev_d.last = 1'b1;
          cur_len_d = '0;
          if (cmd_i.op == CMD_CLR_LINE_CR) begin
            cr_pending_d = 1'b0;
          end
          cmd_pop_o = 1'b1;
        end
        CMD_PLAIN: begin
          if (c == CH_CR) begin
            cr_pending_d = 1'b1;
            cmd_pop_o    = 1'b1;
          end else if (c == CH_LF) begin
            cmd_pop_o = 1'b1;
            if (cur_len_q != 8'd0) begin
              emit             = 1'b1;
              ev_d.kind        = EV_COMMIT;
              ev_d.line_length = cur_len_q;
              ev_d.last        = 1'b1;
              cur_len_d        = '0;
              cr_pending_d     = 1'b0;
              if (ring_count_q < CNT_W'(HISTORY_DEPTH)) begin
                ev_d.position = 8'(slot);
                ring_count_d  = ring_count_q + 1'b1;
              end else begin
                ev_d.position = 8'(ring_head_q);
                ring_head_d   = (head_p1 == (RING_W+1)'(HISTORY_DEPTH)) ?
                                '0 : head_p1[RING_W-1:0];
              end
            end
          end else if (cr_pending_q) begin
            // the byte itself stays at the queue head and is handled later if it still has work
            emit         = 1'b1;
            ev_d.kind    = EV_CLEAR_LINE;
            ev_d.last    = !(is_print || is_tab);
            cur_len_d    = '0;
            cr_pending_d = 1'b0;
            cmd_pop_o    = !(is_print || is_tab);
          end else if (c == CH_BS || c == CH_DEL) begin
            cmd_pop_o = 1'b1;
            if (cur_len_q != 8'd0) begin
              emit             = 1'b1;
              ev_d.kind        = EV_ERASE;
              ev_d.line_length = cur_len_q - 8'd1;
              ev_d.last        = 1'b1;
              cur_len_d        = cur_len_q - 8'd1;
            end
          end else if ((c < CH_SPACE && !is_tab) || line_full) begin
            cmd_pop_o = 1'b1;
          end else begin
            emit             = 1'b1;
            ev_d.kind        = EV_PUT;
            ev_d.position    = cur_len_q;
            ev_d.char_out    = is_tab ? CH_SPACE : c;
            ev_d.line_length = len_p1[7:0];
            cur_len_d        = len_p1[7:0];
            if (is_tab) begin
              ev_d.last = tab_end;
              cmd_pop_o = tab_end;
              tab_cnt_d = tab_end ? 2'd0 : tab_cnt_q + 2'd1;
            end else begin
              ev_d.last = 1'b1;
              cmd_pop_o = 1'b1;
            end
          end
        end
        default: begin
          cmd_pop_o = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cr_pending_q <= 1'b0;
      cur_len_q    <= '0;
      ring_head_q  <= '0;
      ring_count_q <= '0;
      tab_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      cr_pending_q <= cr_pending_d;
      cur_len_q    <= cur_len_d;
      ring_head_q  <= ring_head_d;
      ring_count_q <= ring_count_d;
      tab_cnt_q    <= tab_cnt_d;
      if (out_free) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && emit) begin
      ev_q <= ev_d;
    end
  end

  assign ev_valid_o = out_valid_q;
  assign ev_o       = ev_q;

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import tslb_pkg::*;

  // Tracks parser, line and ring state and queues the edit events each byte should give.
  class edit_event_tracker;
    bit          esc_seen;
    bit          csi_open;
    bit          cr_held;
    int unsigned csi_arg;
    int unsigned line_len;
    int unsigned hist_head;
    int unsigned hist_count;
    event_t      pending_edits[$];
    event_t      burst[$];
    int          errors;

    function void add_edit(ev_kind_e kind, int unsigned pos, int unsigned ch,
                           int unsigned len);
      event_t e;
      e.kind        = kind;
      e.position    = pos[7:0];
      e.char_out    = ch[7:0];
      e.line_length = len[7:0];
      e.last        = 1'b0;
      burst.push_back(e);
    endfunction

    function void csi_action(logic [7:0] c);
      if (c == CH_UP_J) begin
        if (csi_arg == 0 || csi_arg == 2) begin
          hist_count = 0;
          hist_head  = 0;
          line_len   = 0;
          cr_held    = 1'b0;
          add_edit(EV_CLEAR_SCREEN, 0, 0, 0);
        end
      end else if (c == CH_UP_H || c == CH_LO_F) begin
        line_len = 0;
        cr_held  = 1'b0;
        add_edit(EV_CLEAR_LINE, 0, 0, 0);
      end else if (c == CH_UP_K) begin
        line_len = 0;
        add_edit(EV_CLEAR_LINE, 0, 0, 0);
      end
    endfunction

    function void plain_char(logic [7:0] c);
      int unsigned slot;
      if (c == CH_ESC) begin
        esc_seen = 1'b1;
        csi_open = 1'b0;
        csi_arg  = 0;
        return;
      end
      if (c == CH_CR) begin
        cr_held = 1'b1;
        return;
      end
      if (c == CH_LF) begin
        // empty line: nothing committed and the CR stays pending
        if (line_len != 0) begin
          if (hist_count < HISTORY_DEPTH_DEF) begin
            slot = (hist_head + hist_count) % HISTORY_DEPTH_DEF;
            hist_count++;
          end else begin
            slot      = hist_head % HISTORY_DEPTH_DEF;
            hist_head = (hist_head + 1) % HISTORY_DEPTH_DEF;
          end
          add_edit(EV_COMMIT, slot, 0, line_len);
          line_len = 0;
          cr_held  = 1'b0;
        end
        return;
      end
      if (cr_held) begin
        line_len = 0;
        cr_held  = 1'b0;
        add_edit(EV_CLEAR_LINE, 0, 0, 0);
      end
      if (c == CH_BS || c == CH_DEL) begin
        if (line_len > 0) begin
          line_len--;
          add_edit(EV_ERASE, 0, 0, line_len);
        end
        return;
      end
      if (c < CH_SPACE && c != CH_TAB) return;
      if (line_len + 1 >= LINE_CHARS_DEF) return;
      if (c == CH_TAB) begin
        for (int i = 0; i < TAB_WIDTH && line_len + 1 < LINE_CHARS_DEF; i++) begin
          add_edit(EV_PUT, line_len, CH_SPACE, line_len + 1);
          line_len++;
        end
        return;
      end
      add_edit(EV_PUT, line_len, c, line_len + 1);
      line_len++;
    endfunction

    function void take_byte(logic [7:0] c);
      int unsigned acc;
      burst.delete();
      if (esc_seen && !csi_open) begin
        if (c == CH_LBRACK) begin
          csi_open = 1'b1;
          csi_arg  = 0;
        end else begin
          // broken escape: drop it and treat the byte as plain
          esc_seen = 1'b0;
          csi_arg  = 0;
          plain_char(c);
        end
      end else if (esc_seen) begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          acc     = csi_arg * 10 + (c - CH_ZERO);
          csi_arg = (acc > 255) ? 255 : acc;
        end else if (c != CH_SEMI && c != CH_QUEST) begin
          if ((c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z))
            csi_action(c);
          esc_seen = 1'b0;
          csi_open = 1'b0;
          csi_arg  = 0;
        end
      end else begin
        plain_char(c);
      end
      if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i]) pending_edits.push_back(burst[i]);
    endfunction

    function void match_event(logic [2:0] kind, logic [7:0] pos, logic [7:0] ch,
                              logic [7:0] len, logic last);
      event_t want;
      if (pending_edits.size() == 0) begin
        $error("unexpected event: kind %0d position %0d char %0d length %0d",
               kind, pos, ch, len);
        errors++;
        return;
      end
      want = pending_edits.pop_front();
      if (kind !== want.kind) begin
        $error("event_kind mismatch: expected %0d, actual %0d", want.kind, kind);
        errors++;
      end
      if (pos !== want.position) begin
        $error("position mismatch: expected %0d, actual %0d", want.position, pos);
        errors++;
      end
      if (ch !== want.char_out) begin
        $error("char_out mismatch: expected %0d, actual %0d", want.char_out, ch);
        errors++;
      end
      if (len !== want.line_length) begin
        $error("line_length mismatch: expected %0d, actual %0d", want.line_length, len);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_event mismatch: expected %0d, actual %0d", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [7:0]  s_data = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [23:0] m_data;
  logic [2:0]  m_user;
  logic        m_last;

  int          tx_idle_pct = 34;
  int          rx_idle_pct = 49;
  bit          rx_hold_req = 1'b0;
  int          bytes_sent = 0;

  edit_event_tracker tracker = new();

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  terminal_stream_line_builder #(
    .LINE_CHARS   (LINE_CHARS_DEF),
    .HISTORY_DEPTH(HISTORY_DEPTH_DEF)
  ) DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user),
    .m_axis_tlast_o (m_last)
  );

  // transaction monitor: values read here are the ones seen at the edge
  always @(posedge clk) begin
    if (rst_n && s_valid && s_ready === 1'b1) tracker.take_byte(s_data);
    if (rst_n && m_valid === 1'b1 && m_ready)
      tracker.match_event(m_user, m_data[7:0], m_data[15:8], m_data[23:16], m_last);
  end

  // receiver: random back-pressure, plus a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = 300;
      end
      if (hold_left > 0) begin
        m_ready <= 1'b0;
        hold_left--;
      end else begin
        m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic push_byte(logic [7:0] b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    @(posedge clk);
    while (s_ready !== 1'b1) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic drain_events();
    s_valid <= 1'b0;
    while (tracker.pending_edits.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1)) return 8'(CH_UP_A + $urandom_range(0, 25));
    return 8'(CH_LO_A + $urandom_range(0, 25));
  endfunction

  task automatic send_text_line();
    int unsigned n;
    int unsigned sel;
    n = $urandom_range(1, 6);
    repeat (n) begin
      sel = $urandom_range(0, 99);
      if (sel < 70)      push_byte(8'($urandom_range(32, 126)));
      else if (sel < 80) push_byte(8'($urandom_range(128, 255)));
      else if (sel < 85) push_byte(CH_TAB);
      else if (sel < 90) push_byte($urandom_range(0, 1) ? CH_BS : CH_DEL);
      else if (sel < 95) push_byte(CH_CR);
      else               push_byte(8'($urandom_range(0, 31)));
    end
    if ($urandom_range(0, 99) < 85) push_byte(CH_LF);
  endtask

  task automatic send_csi();
    int unsigned sel;
    int unsigned n;
    push_byte(CH_ESC);
    push_byte(CH_LBRACK);
    sel = $urandom_range(0, 3);
    if (sel == 1) push_byte(CH_ZERO);
    else if (sel == 2) push_byte(8'(CH_ZERO + 2));
    else if (sel == 3) begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        case ($urandom_range(0, 5))
          0:       push_byte(CH_SEMI);
          1:       push_byte(CH_QUEST);
          default: push_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
        endcase
      end
    end
    case ($urandom_range(0, 9))
      0:       push_byte(CH_UP_J);
      1, 2:    push_byte(CH_UP_K);
      3, 4:    push_byte(CH_UP_H);
      5:       push_byte(CH_LO_F);
      6, 7:    push_byte(rand_letter());
      8:       push_byte(8'($urandom_range(0, 255)));
      default: begin
        // parameter past 255 saturates; J then does nothing
        repeat (3) push_byte(8'($urandom_range(CH_ZERO + 3, CH_NINE)));
        push_byte(CH_UP_J);
      end
    endcase
  endtask

  task automatic send_long_line();
    int unsigned n;
    // mostly tabs, towards the column limit, so later puts and the last tab may be cut short
    n = $urandom_range(40, 43);
    repeat (n) begin
      if ($urandom_range(0, 4) == 0) push_byte(8'($urandom_range(32, 255)));
      else push_byte(CH_TAB);
    end
    repeat (2) push_byte(8'($urandom_range(33, 126)));
    push_byte(CH_DEL);
    push_byte(CH_LF);
  endtask

  task automatic send_mixed(int target);
    int unsigned sel;
    while (bytes_sent < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 65) send_text_line();
      else if (sel < 80) send_csi();
      else if (sel < 90) push_byte(8'($urandom_range(0, 255)));
      else begin
        push_byte(CH_ESC);
        if ($urandom_range(0, 1)) push_byte(CH_LBRACK);
        push_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    logic [7:0] directed[$];
    directed = '{8'h41, 8'hFF, CH_TAB, CH_BS, CH_DEL, CH_CR, 8'h62, CH_LF, CH_LF,
                 CH_CR, 8'h00, CH_BS, CH_ESC, 8'h78, CH_ESC, CH_LBRACK, CH_NINE,
                 CH_NINE, CH_NINE, CH_UP_J, CH_ESC, CH_LBRACK, CH_LO_F, CH_ESC,
                 CH_LBRACK, CH_UP_J};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) push_byte(directed[i]);
    send_mixed(bytes_sent + 40);
    send_long_line();
    send_mixed(bytes_sent + 110);
    drain_events();

    tx_idle_pct = 49;
    rx_idle_pct = 34;
    send_long_line();
    send_mixed(bytes_sent + 100);
    drain_events();

    // no idling; long receiver hold-off while short lines wrap the history ring
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_req = 1'b1;
    repeat (66) begin
      push_byte(8'($urandom_range(32, 255)));
      push_byte(CH_LF);
    end
    drain_events();
    repeat (20) @(posedge clk);

    if (tracker.errors == 0 && tracker.pending_edits.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
